### hw/rtl/kts_pkg.sv
`default_nettype none
package kts_pkg;

  localparam int DEF_MAX_KEYS = 64;
  localparam int FRAC_BITS    = 16;
  localparam int FW           = FRAC_BITS + 1;
  localparam logic [FW-1:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  localparam int CFG_W = 7;

  // register indexes
  localparam logic REG_TRACK_KIND = 1'b0;
  localparam logic REG_KEY_COUNT  = 1'b1;

  // opcodes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // track kinds
  localparam logic KIND_VECTOR = 1'b0;
  localparam logic KIND_QUAT   = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [5:0]         key_slot;
    logic [31:0]        time_point;
    logic signed [31:0] comp_x;
    logic signed [31:0] comp_y;
    logic signed [31:0] comp_z;
    logic signed [31:0] comp_w;
  } sample_req_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
    logic [16:0]        blend_factor;
    logic [5:0]         segment_index;
  } sample_rsp_t;

  typedef struct packed {
    logic [31:0]        time_point;
    logic signed [31:0] comp_x;
    logic signed [31:0] comp_y;
    logic signed [31:0] comp_z;
    logic signed [31:0] comp_w;
  } key_rec_t;

  typedef struct packed {
    logic     is_sample;
    logic     slot_ok;
    logic [5:0] slot;
    key_rec_t rec;
  } cmd_t;

  typedef enum logic [4:0] {
    B_IDLE, B_CHK, B_SCAN, B_FLO, B_FHI, B_FCAP, B_FRAC, B_DIV,
    B_DOT, B_SIGN, B_BLEND, B_SQ, B_SQSET, B_SQRT, B_NSET, B_NORM, B_OUT
  } back_state_t;

endpackage
`default_nettype wire

### hw/rtl/kts_front.sv
`default_nettype none
module kts_front #(
  parameter int MAX_KEYS = kts_pkg::DEF_MAX_KEYS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  kts_pkg::sample_req_t req,
  output logic                cmd_valid,
  output kts_pkg::cmd_t       cmd,
  input  logic                cmd_pop
);
  import kts_pkg::*;

  localparam int DEPTH = 2;
  localparam int PW    = 1;
  localparam int CW    = 2;

  cmd_t          fifo [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  cmd_t          cls;
  logic          push_ok;
  logic          pop_ok;

  // decode the request
  always_comb begin
    cls.is_sample          = (req.opcode == OP_SAMPLE);
    cls.slot_ok            = (32'(req.key_slot) < MAX_KEYS);
    cls.slot               = req.key_slot;
    cls.rec.time_point     = req.time_point;
    cls.rec.comp_x         = req.comp_x;
    cls.rec.comp_y         = req.comp_y;
    cls.rec.comp_z         = req.comp_z;
    cls.rec.comp_w         = req.comp_w;
  end

  assign full      = (count == CW'(DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = fifo[rd_ptr];
  assign push_ok   = push && !full;
  assign pop_ok    = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) wr_ptr <= wr_ptr + 1'b1;
      if (pop_ok)  rd_ptr <= rd_ptr + 1'b1;
      if (push_ok && !pop_ok)      count <= count + 1'b1;
      else if (!push_ok && pop_ok) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) fifo[wr_ptr] <= cls;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH)) else $error("queue count overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid) else $error("pop from empty queue");
  a_count_inc: assert property (@(posedge clk) disable iff (rst)
    push_ok && !pop_ok |=> count == $past(count) + 1'b1) else $error("count slip");

endmodule
`default_nettype wire

### hw/rtl/kts_back.sv
`default_nettype none
module kts_back #(
  parameter int MAX_KEYS = kts_pkg::DEF_MAX_KEYS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  kts_pkg::cmd_t       cmd,
  output logic                cmd_pop,
  input  logic                track_kind,
  input  logic [6:0]          key_count,
  output logic                empty,
  input  logic                pop,
  output kts_pkg::sample_rsp_t rsp
);
  import kts_pkg::*;

  localparam int IW = $clog2(MAX_KEYS);
  localparam int NW = $clog2(MAX_KEYS + 1);

  back_state_t state, state_next;

  key_rec_t          mem [MAX_KEYS];
  key_rec_t          rdata;
  logic [NW-1:0]     rd_addr;
  logic              mem_we;

  logic [NW-1:0]     n;
  logic [NW-1:0]     chk;
  logic [IW-1:0]     cached_index;
  logic [IW-1:0]     cached_clamp;
  logic [IW-1:0]     lo;
  logic [IW-1:0]     hi;
  logic [31:0]       t;
  logic [31:0]       tlo;
  logic [31:0]       thi;
  logic signed [32:0] a [4];
  logic signed [32:0] b [4];
  logic signed [32:0] q [4];

  logic [FW-1:0]     f;
  logic [31:0]       rem;
  logic [31:0]       ud;
  logic [4:0]        cnt;
  logic [1:0]        k;
  logic [1:0]        ph;
  logic [1:0]        last_k;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] prod;
  logic signed [67:0] acc;
  logic signed [67:0] bsum;

  logic [63:0]       sv;
  logic [63:0]       res;
  logic [63:0]       bitv;
  logic [63:0]       rb;
  logic [63:0]       res_next;
  logic [63:0]       ssat;
  logic [32:0]       len;
  logic [32:0]       nrem;
  logic [17:0]       dlow;
  logic [17:0]       quot;
  logic [17:0]       quot_next;
  logic              qneg;
  logic [33:0]       nr2;
  logic [32:0]       mag;
  logic [49:0]       dnum;

  logic              scan_stop;
  logic              scan_pass;
  logic [NW-1:0]     scan_start;
  logic signed [32:0] num;
  logic signed [32:0] den;
  logic [31:0]       un;
  logic [31:0]       ud_c;
  logic              frac_div;
  logic [FW-1:0]     frac_fix;
  logic [32:0]       dr2;
  back_state_t       post_frac;

  sample_rsp_t       rsp_reg;
  logic              rsp_full;

  // effective key count and clamped cached index
  always_comb begin
    if (key_count == '0)               n = NW'(1);
    else if (32'(key_count) > MAX_KEYS) n = NW'(MAX_KEYS);
    else                               n = NW'(key_count);
    if (NW'(cached_index) > n - 1'b1)  cached_clamp = IW'(n - 1'b1);
    else                               cached_clamp = cached_index;
  end

  // search and fraction decisions
  always_comb begin
    if (t < rdata.time_point) scan_start = '0;
    else if (chk != '0)       scan_start = chk - 1'b1;
    else                      scan_start = '0;
    scan_pass = (chk < n) && (rdata.time_point <= t);
    scan_stop = !scan_pass;

    num  = $signed({1'b0, t})   - $signed({1'b0, tlo});
    den  = $signed({1'b0, thi}) - $signed({1'b0, tlo});
    un   = num[32] ? 32'(-num) : 32'(num);
    ud_c = den[32] ? 32'(-den) : 32'(den);
    frac_div = 1'b0;
    if (den == '0)                         frac_fix = FRAC_ONE;
    else if (num == '0 || num[32] != den[32]) frac_fix = '0;
    else if (un >= ud_c)                    frac_fix = FRAC_ONE;
    else begin
      frac_fix = '0;
      frac_div = 1'b1;
    end
    dr2       = {rem, 1'b0};
    post_frac = (track_kind == KIND_QUAT) ? B_DOT : B_BLEND;
    last_k    = (track_kind == KIND_QUAT) ? 2'd3 : 2'd2;
  end

  // shared multiplier operands
  always_comb begin
    case (state)
      B_BLEND: begin
        if (ph == 2'd0) begin
          mul_a = a[k];
          mul_b = $signed(33'(FRAC_ONE - f));
        end else begin
          mul_a = b[k];
          mul_b = $signed(33'(f));
        end
      end
      B_SQ: begin
        mul_a = q[k];
        mul_b = q[k];
      end
      default: begin
        mul_a = a[k];
        mul_b = b[k];
      end
    endcase
    bsum = acc + 68'(prod) + 68'(1 << (FRAC_BITS - 1));
  end

  // root and normalize steps
  always_comb begin
    rb = res + bitv;
    if (sv >= rb) res_next = (res >> 1) + bitv;
    else          res_next = res >> 1;
    ssat = (acc[67:64] != '0) ? '1 : acc[63:0];
    mag  = q[k][32] ? 33'(-q[k]) : 33'(q[k]);
    dnum = {1'b0, mag, 16'b0} + 50'(len >> 1);
    nr2  = {nrem, dlow[17]};
    if (nr2 >= {1'b0, len}) quot_next = {quot[16:0], 1'b1};
    else                    quot_next = {quot[16:0], 1'b0};
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:  if (cmd_valid && cmd.is_sample) state_next = B_CHK;
      B_CHK:   state_next = B_SCAN;
      B_SCAN:  if (scan_stop) state_next = B_FLO;
      B_FLO:   state_next = B_FHI;
      B_FHI:   state_next = B_FCAP;
      B_FCAP:  state_next = B_FRAC;
      B_FRAC:  state_next = frac_div ? B_DIV : post_frac;
      B_DIV:   if (cnt == '0) state_next = post_frac;
      B_DOT:   if (ph == 2'd1 && k == 2'd3) state_next = B_SIGN;
      B_SIGN:  state_next = B_BLEND;
      B_BLEND: begin
        if (ph == 2'd2 && k == last_k)
          state_next = (track_kind == KIND_QUAT) ? B_SQ : B_OUT;
      end
      B_SQ:    if (ph == 2'd1 && k == 2'd3) state_next = B_SQSET;
      B_SQSET: state_next = (ssat == '0) ? B_OUT : B_SQRT;
      B_SQRT:  if (bitv == 64'd1) state_next = B_NSET;
      B_NSET:  state_next = B_NORM;
      B_NORM:  if (cnt == '0) state_next = (k == 2'd3) ? B_OUT : B_NSET;
      B_OUT:   if (!rsp_full) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    cmd_pop = 1'b0;
    mem_we  = 1'b0;
    rd_addr = chk;
    case (state)
      B_IDLE: begin
        cmd_pop = cmd_valid;
        mem_we  = cmd_valid && !cmd.is_sample && cmd.slot_ok;
        rd_addr = NW'(cached_clamp);
      end
      B_CHK:   rd_addr = scan_start;
      B_SCAN:  rd_addr = chk + 1'b1;
      B_FLO:   rd_addr = NW'(lo);
      B_FHI:   rd_addr = NW'(hi);
      default: rd_addr = chk;
    endcase
  end

  // key store
  always_ff @(posedge clk) begin
    if (mem_we) mem[IW'(cmd.slot)] <= cmd.rec;
    rdata <= mem[rd_addr[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      cached_index <= '0;
      rsp_full     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_SCAN && scan_stop) begin
        if (chk >= n) cached_index <= IW'(n - 1'b1);
        else          cached_index <= chk[IW-1:0];
      end
      if (state == B_OUT && !rsp_full) rsp_full <= 1'b1;
      else if (pop && rsp_full)        rsp_full <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    chk  <= rd_addr;
    prod <= mul_a * mul_b;
    case (state)
      B_IDLE: t <= cmd.rec.time_point;
      B_CHK: begin
        lo <= '0;
        hi <= IW'(n - 1'b1);
      end
      B_SCAN: begin
        if (scan_pass) lo <= chk[IW-1:0];
        else if (chk < n) hi <= chk[IW-1:0];
      end
      B_FHI: begin
        tlo  <= rdata.time_point;
        a[0] <= 33'(rdata.comp_x);
        a[1] <= 33'(rdata.comp_y);
        a[2] <= 33'(rdata.comp_z);
        a[3] <= 33'(rdata.comp_w);
      end
      B_FCAP: begin
        thi  <= rdata.time_point;
        b[0] <= 33'(rdata.comp_x);
        b[1] <= 33'(rdata.comp_y);
        b[2] <= 33'(rdata.comp_z);
        b[3] <= 33'(rdata.comp_w);
      end
      B_FRAC: begin
        f   <= frac_fix;
        rem <= un;
        ud  <= ud_c;
        cnt <= 5'd15;
        k   <= '0;
        ph  <= '0;
        acc <= '0;
      end
      B_DIV: begin
        if (dr2 >= {1'b0, ud}) begin
          rem <= 32'(dr2 - {1'b0, ud});
          f   <= {f[FW-2:0], 1'b1};
        end else begin
          rem <= dr2[31:0];
          f   <= {f[FW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
      end
      B_DOT: begin
        if (ph == 2'd0) ph <= 2'd1;
        else begin
          acc <= acc + 68'(prod);
          ph  <= 2'd0;
          k   <= k + 1'b1;
        end
      end
      B_SIGN: begin
        // take the short way round
        if (acc[67]) begin
          b[0] <= -b[0];
          b[1] <= -b[1];
          b[2] <= -b[2];
          b[3] <= -b[3];
        end
        k  <= '0;
        ph <= '0;
      end
      B_BLEND: begin
        case (ph)
          2'd0: ph <= 2'd1;
          2'd1: begin
            acc <= 68'(prod);
            ph  <= 2'd2;
          end
          default: begin
            q[k] <= 33'(bsum >>> FRAC_BITS);
            ph   <= 2'd0;
            if (k == last_k) begin
              k   <= '0;
              acc <= '0;
              if (track_kind == KIND_VECTOR) q[3] <= '0;
            end else begin
              k <= k + 1'b1;
            end
          end
        endcase
      end
      B_SQ: begin
        if (ph == 2'd0) ph <= 2'd1;
        else begin
          acc <= acc + 68'(prod);
          ph  <= 2'd0;
          k   <= k + 1'b1;
        end
      end
      B_SQSET: begin
        sv   <= ssat;
        res  <= '0;
        bitv <= 64'd1 << 62;
        k    <= '0;
      end
      B_SQRT: begin
        if (sv >= rb) sv <= sv - rb;
        res  <= res_next;
        bitv <= bitv >> 2;
        len  <= 33'(res_next);
      end
      B_NSET: begin
        nrem <= 33'(dnum >> 18);
        dlow <= dnum[17:0];
        quot <= '0;
        qneg <= q[k][32];
        cnt  <= 5'd17;
      end
      B_NORM: begin
        if (nr2 >= {1'b0, len}) nrem <= 33'(nr2 - {1'b0, len});
        else                    nrem <= nr2[32:0];
        dlow <= {dlow[16:0], 1'b0};
        quot <= quot_next;
        cnt  <= cnt - 1'b1;
        if (cnt == '0) begin
          q[k] <= qneg ? -33'(quot_next) : 33'(quot_next);
          k    <= k + 1'b1;
        end
      end
      B_OUT: begin
        if (!rsp_full) begin
          rsp_reg.out_x         <= q[0][31:0];
          rsp_reg.out_y         <= q[1][31:0];
          rsp_reg.out_z         <= q[2][31:0];
          rsp_reg.out_w         <= q[3][31:0];
          rsp_reg.blend_factor  <= 17'(f);
          rsp_reg.segment_index <= 6'(cached_index);
        end
      end
      default: ;
    endcase
  end

  assign empty = !rsp_full;
  assign rsp   = rsp_reg;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_full && !pop |=> rsp_full) else $error("result lost");
  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    state == B_OUT |-> f <= FRAC_ONE) else $error("fraction above one");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> state == B_IDLE) else $error("request taken while busy");
  a_lo_behind: assert property (@(posedge clk) disable iff (rst)
    state == B_SCAN |-> NW'(lo) <= chk) else $error("low key ahead of scan");

endmodule
`default_nettype wire

### hw/rtl/keyframe_track_sampler.sv
`default_nettype none
// keyframe track sampler: holds one track of up to MAX_KEYS timed keys and
// answers sample requests with a lerped vector (track_kind 0) or a
// sign-corrected, renormalised quaternion blend (track_kind 1), all Q16.16.
// write requests store a key and give no result; each sample request gives
// one result. requests enter a two-deep queue, so new requests are taken
// while a result waits on the output register. a write is done in the
// sequencer's idle state. a sample runs on a single-port key store, a shared
// multiplier, and bit-serial divide and root units: a key scan of one key
// per cycle, the fraction divide, then the blend for a vector track, or a
// dot product, sign fix, blend, sum of squares, root and four normalising
// divides for a quaternion track (the root gives one result bit per cycle,
// each normalising divide a setup step, then one quotient bit per cycle).
// the cached segment index speeds up samples that move forward in time
module keyframe_track_sampler #(
  parameter int MAX_KEYS = kts_pkg::DEF_MAX_KEYS
) (
  input  logic                 clk,
  input  logic                 rst,
  // request side
  input  logic                 push,
  output logic                 full,
  input  kts_pkg::sample_req_t req,
  // result side
  output logic                 empty,
  input  logic                 pop,
  output kts_pkg::sample_rsp_t rsp,
  // register writes
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [kts_pkg::CFG_W-1:0] cfg_data
);
  import kts_pkg::*;

  logic       track_kind;
  logic [6:0] key_count;
  logic       cmd_valid;
  logic       cmd_pop;
  cmd_t       cmd;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      track_kind <= KIND_VECTOR;
      key_count  <= 7'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TRACK_KIND: track_kind <= cfg_data[0];
        REG_KEY_COUNT:  key_count  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // request decode and queue
  kts_front #(.MAX_KEYS(MAX_KEYS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // key store, search and arithmetic
  kts_back #(.MAX_KEYS(MAX_KEYS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .track_kind (track_kind),
    .key_count  (key_count),
    .empty      (empty),
    .pop        (pop),
    .rsp        (rsp)
  );

endmodule
`default_nettype wire

### tb/kts_checker.sv
module kts_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic                 full,
  input  kts_pkg::sample_req_t req,
  input  logic                 empty,
  input  logic                 pop,
  input  kts_pkg::sample_rsp_t rsp,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [kts_pkg::CFG_W-1:0] cfg_data,
  output int                   errors,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import kts_pkg::*;

  localparam int NKEYS = DEF_MAX_KEYS;
  localparam longint ONE = longint'(1) << FRAC_BITS;

  logic [31:0]        key_time_m [NKEYS];
  logic signed [31:0] key_comp_m [NKEYS][4];
  logic [5:0]         cached_seg;
  logic               kind_r;
  logic [6:0]         count_r;

  sample_rsp_t expected_rsp_q[$];

  initial errors = 0;
  assign pending = expected_rsp_q.size();

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic longint lerp_q(longint a, longint b, longint f);
    longint s;
    s = a * (ONE - f) + b * f + (longint'(1) << (FRAC_BITS - 1));
    return s >>> FRAC_BITS;
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned res, bit_m;
    res = 0;
    bit_m = longint'(1) << 62;
    while (bit_m > v) bit_m >>= 2;
    while (bit_m != 0) begin
      if (v >= res + bit_m) begin
        v -= res + bit_m;
        res = (res >> 1) + bit_m;
      end else begin
        res >>= 1;
      end
      bit_m >>= 2;
    end
    return res;
  endfunction

  // sample prediction, also advances the cached segment
  function automatic sample_rsp_t predict_sample(logic [31:0] t);
    int unsigned n, idx, lo, hi;
    longint f, num, den, qs, rs, p, v, r;
    longint a[4], b[4], q[4];
    longint unsigned s, sq, len, mag, un, ud, quo;
    sample_rsp_t o;
    n = (count_r == 0) ? 1 : (count_r > NKEYS) ? NKEYS : count_r;
    idx = cached_seg;
    if (idx > n - 1) idx = n - 1;
    if (t < key_time_m[idx]) idx = 0;
    idx = (idx != 0) ? idx - 1 : 0;
    lo = 0;
    hi = n - 1;
    while (idx < n) begin
      if (key_time_m[idx] <= t) begin
        lo = idx;
        idx++;
      end else begin
        hi = idx;
        break;
      end
    end
    if (idx > n - 1) idx = n - 1;
    cached_seg = 6'(idx);
    num = longint'(t) - longint'(key_time_m[lo]);
    den = longint'(key_time_m[hi]) - longint'(key_time_m[lo]);
    if (den == 0) f = ONE;
    else if (num == 0 || ((num < 0) != (den < 0))) f = 0;
    else begin
      un = (num < 0) ? -num : num;
      ud = (den < 0) ? -den : den;
      quo = (un << FRAC_BITS) / ud;
      f = (quo > ONE) ? ONE : longint'(quo);
    end
    for (int k = 0; k < 4; k++) begin
      a[k] = key_comp_m[lo][k];
      b[k] = key_comp_m[hi][k];
    end
    if (kind_r == KIND_VECTOR) begin
      for (int k = 0; k < 3; k++) q[k] = lerp_q(a[k], b[k], f);
      q[3] = 0;
    end else begin
      // exact dot product without 64-bit overflow
      qs = 0;
      rs = 0;
      for (int k = 0; k < 4; k++) begin
        p = a[k] * b[k];
        qs += p >>> 2;
        rs += p & 3;
      end
      qs += rs >>> 2;
      if (qs < 0)
        for (int k = 0; k < 4; k++) b[k] = -b[k];
      s = 0;
      for (int k = 0; k < 4; k++) begin
        q[k] = lerp_q(a[k], b[k], f);
        sq = q[k] * q[k];
        s = (s > 64'hFFFF_FFFF_FFFF_FFFF - sq) ? 64'hFFFF_FFFF_FFFF_FFFF : s + sq;
      end
      if (s != 0) begin
        len = root64(s);
        for (int k = 0; k < 4; k++) begin
          v = q[k] * 65536;
          mag = (v < 0) ? -v : v;
          r = longint'((mag + len / 2) / len);
          q[k] = (v < 0) ? -r : r;
        end
      end
    end
    o.out_x = q[0][31:0];
    o.out_y = q[1][31:0];
    o.out_z = q[2][31:0];
    o.out_w = q[3][31:0];
    o.blend_factor = f[16:0];
    o.segment_index = cached_seg;
    return o;
  endfunction

  always @(posedge clk) begin
    sample_rsp_t want;
    if (rst) begin
      cached_seg = '0;
      kind_r = KIND_VECTOR;
      count_r = 7'd1;
      expected_rsp_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_TRACK_KIND) kind_r = cfg_data[0];
        else count_r = cfg_data;
      end
      if (push && !full) begin
        if (req.opcode == OP_WRITE) begin
          key_time_m[req.key_slot] = req.time_point;
          key_comp_m[req.key_slot][0] = req.comp_x;
          key_comp_m[req.key_slot][1] = req.comp_y;
          key_comp_m[req.key_slot][2] = req.comp_z;
          key_comp_m[req.key_slot][3] = req.comp_w;
        end else begin
          expected_rsp_q.insert(expected_rsp_q.size(), predict_sample(req.time_point));
        end
      end
      if (pop && !empty) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("unexpected result", rsp.out_x, 0);
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp.out_x !== want.out_x) report_mismatch("out_x", rsp.out_x, want.out_x);
          if (rsp.out_y !== want.out_y) report_mismatch("out_y", rsp.out_y, want.out_y);
          if (rsp.out_z !== want.out_z) report_mismatch("out_z", rsp.out_z, want.out_z);
          if (rsp.out_w !== want.out_w) report_mismatch("out_w", rsp.out_w, want.out_w);
          if (rsp.blend_factor !== want.blend_factor)
            report_mismatch("blend_factor", rsp.blend_factor, want.blend_factor);
          if (rsp.segment_index !== want.segment_index)
            report_mismatch("segment_index", rsp.segment_index, want.segment_index);
        end
      end
    end
  end
endmodule

### tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import kts_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  sample_req_t req = '0;
  logic empty;
  logic pop = 1'b0;
  sample_rsp_t rsp;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_TRACK_KIND;
  logic [CFG_W-1:0] cfg_data = '0;
  int errors;
  int pending;
  int request_count = 0;
  bit no_idle = 1'b0;
  logic [31:0] key_t [64];

  always #5 clk = ~clk;

  keyframe_track_sampler uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .req(req),
    .empty(empty), .pop(pop), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  kts_checker checker_i (
    .clk(clk), .rst(rst), .push(push), .full(full), .req(req),
    .empty(empty), .pop(pop), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3, 4: return $urandom_range(0, 131072) - 65536;
      default: return $urandom;
    endcase
  endfunction

  // every call starts and ends at a falling edge; push stays high between
  // back-to-back requests
  task automatic send_request(sample_req_t item);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    push = 1'b1;
    req = item;
    // full is stable from the falling edge to the next rising edge
    while (full) @(negedge clk);
    @(negedge clk);
    request_count++;
  endtask

  task automatic write_key(int slot, logic [31:0] t, logic [31:0] x, logic [31:0] y,
                           logic [31:0] z, logic [31:0] w);
    sample_req_t item;
    item.opcode = OP_WRITE;
    item.key_slot = 6'(slot);
    item.time_point = t;
    item.comp_x = x;
    item.comp_y = y;
    item.comp_z = z;
    item.comp_w = w;
    key_t[slot] = t;
    send_request(item);
  endtask

  task automatic sample_at(logic [31:0] t);
    sample_req_t item;
    item.opcode = OP_SAMPLE;
    item.key_slot = 6'($urandom);
    item.time_point = t;
    item.comp_x = $urandom;
    item.comp_y = $urandom;
    item.comp_z = $urandom;
    item.comp_w = $urandom;
    send_request(item);
  endtask

  // registers change only with the block drained and quiet
  task automatic set_config(logic kind, logic [6:0] count);
    push = 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = REG_TRACK_KIND;
    cfg_data = {6'd0, kind};
    @(negedge clk);
    cfg_index = REG_KEY_COUNT;
    cfg_data = count;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // result side: random pop stalls
  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        pop = 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop = 1'b1;
      @(negedge clk);
    end
  end

  initial begin
    #50ms;
    $display("keyframe_track_sampler: mismatch");
    $finish;
  end

  initial begin
    int n, nsamp;
    logic kind;
    logic [6:0] count;
    logic [31:0] t, step;
    repeat (11) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // fill every slot first so no sample ever reads an unwritten key
    for (int i = 0; i < 64; i++)
      write_key(i, i * 32'h0001_0000, rand_comp(), rand_comp(), rand_comp(), rand_comp());

    // directed: single key, time extremes, vector and quaternion
    sample_at(32'h0);
    sample_at(32'hFFFF_FFFF);
    set_config(KIND_VECTOR, 7'd2);
    write_key(0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0);
    write_key(1, 32'h0002_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0);
    sample_at(32'h0);
    sample_at(32'h0001_0000);
    sample_at(32'h0001_8001);
    sample_at(32'hFFFF_FFFF);
    set_config(KIND_QUAT, 7'd2);
    sample_at(32'h0000_8000);
    // zero-length quaternion keys
    write_key(0, 32'h10, 32'h0, 32'h0, 32'h0, 32'h0);
    write_key(1, 32'h20, 32'h0, 32'h0, 32'h0, 32'h0);
    sample_at(32'h18);
    // opposite-sign quaternions and equal times
    write_key(0, 32'h100, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
    write_key(1, 32'h100, 32'hFFFF_0000, 32'h0, 32'h0, 32'h100);
    sample_at(32'h100);
    // unsorted keys and out-of-range counts
    write_key(1, 32'h50, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    sample_at(32'h80);
    set_config(KIND_QUAT, 7'd0);
    sample_at(32'h0);
    set_config(KIND_VECTOR, 7'd127);
    sample_at(32'h7FFF_0000);

    // random phases: mostly sorted tracks swept forward in time
    while (request_count < 2000) begin
      kind = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0: count = 7'd1;
        1: count = 7'd64;
        2: count = 7'd0;
        3: count = 7'($urandom_range(65, 127));
        4, 5: count = 7'($urandom_range(2, 64));
        default: count = 7'($urandom_range(2, 8));
      endcase
      set_config(kind, count);
      no_idle = ($urandom_range(0, 4) == 0);
      n = (count == 0) ? 1 : (count > 64) ? 64 : count;
      t = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4096);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0) step = 0;
        else if ($urandom_range(0, 9) == 0) step = $urandom;
        else step = $urandom_range(1, 65536);
        write_key(i, ($urandom_range(0, 7) == 0) ? $urandom : t,
                  rand_comp(), rand_comp(), rand_comp(), rand_comp());
        t += step;
      end
      // a stray write now and then, to any slot
      if ($urandom_range(0, 3) == 0)
        write_key($urandom_range(0, 63), $urandom, $urandom, $urandom, $urandom, $urandom);
      nsamp = $urandom_range(10, 40);
      t = key_t[0] - $urandom_range(0, 100);
      for (int i = 0; i < nsamp; i++) begin
        case ($urandom_range(0, 19))
          0, 1, 2: t = key_t[$urandom_range(0, n - 1)];
          3: t = $urandom;
          4: t = 32'hFFFF_FFFF;
          default: t += $urandom_range(0, 40000);
        endcase
        sample_at(t);
      end
    end
    push = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (400) @(negedge clk);
    if (errors == 0) begin
      $display("keyframe_track_sampler: match");
    end else begin
      $display("keyframe_track_sampler: mismatch");
    end
    $finish;
  end
endmodule
